// ===== hw/rtl/dcb_pkg.sv =====
`timescale 1ns / 1ps

package dcb_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 15;
  localparam int unsigned CoeffW  = 15;
  localparam int unsigned RampW   = 11;
  localparam int unsigned BlenW   = 16;
  localparam int unsigned HistW   = 32;
  localparam int unsigned StepW   = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned QShift  = 15;

  localparam logic [CoeffW-1:0] CoeffReset  = CoeffW'(29334);
  localparam logic [GainW-1:0]  TargetReset = GainW'(13045);
  localparam logic [RampW-1:0]  RampReset   = RampW'(661);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HPF_COEFF   = 2'd0,
    CFG_TARGET_GAIN = 2'd1,
    CFG_RAMP_LEN    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_in;
    logic                      channel;
    logic                      buffer_first;
    logic [BlenW-1:0]          buffer_len;
    logic                      clear_history;
  } dcb_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic [GainW-1:0]          gain_now;
  } dcb_out_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic step_zero;
    logic div_init;
    logic div_iter;
    logic div_end;
    logic mul_hpf;
    logic add_hpf;
    logic mul_gain;
    logic write;
  } dcb_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic gains_equal;
    logic out_full;
  } dcb_sts_t;

endpackage

// ===== hw/rtl/dcb_stream_if.sv =====
`timescale 1ns / 1ps

interface dcb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dcb_ctrl.sv =====
`timescale 1ns / 1ps

module dcb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_first_i,
  output logic              in_ready_o,
  input  dcb_pkg::dcb_sts_t sts_i,
  output dcb_pkg::dcb_cmd_t cmd_o
);
  import dcb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_MUL_HPF,
    ST_ADD_HPF,
    ST_MUL_GAIN,
    ST_WRITE
  } state_e;

  localparam int unsigned DivIters = GainW;
  localparam int unsigned CntW     = $clog2(DivIters);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        if (accept) begin
          state_d = in_first_i ? ST_DIV_START : ST_MUL_HPF;
        end
      end
      ST_DIV_START: begin
        if (sts_i.gains_equal) begin
          cmd_o.step_zero = 1'b1;
          state_d         = ST_MUL_HPF;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = CntW'(DivIters - 1);
          state_d        = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        cmd_o.div_iter = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DIV_END;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIV_END: begin
        cmd_o.div_end = 1'b1;
        state_d       = ST_MUL_HPF;
      end
      ST_MUL_HPF: begin
        cmd_o.mul_hpf = 1'b1;
        state_d       = ST_ADD_HPF;
      end
      ST_ADD_HPF: begin
        cmd_o.add_hpf = 1'b1;
        state_d       = ST_MUL_GAIN;
      end
      ST_MUL_GAIN: begin
        cmd_o.mul_gain = 1'b1;
        state_d        = ST_WRITE;
      end
      ST_WRITE: begin
        if (!sts_i.out_full) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/dcb_datapath.sv =====
`timescale 1ns / 1ps

module dcb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dcb_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [dcb_pkg::CfgW-1:0]            cfg_data_i,
  input  dcb_pkg::dcb_in_t                    in_data_i,
  input  dcb_pkg::dcb_cmd_t                   cmd_i,
  output dcb_pkg::dcb_sts_t                   sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output dcb_pkg::dcb_out_t                   out_data_o
);
  import dcb_pkg::*;

  localparam int unsigned P1W = CoeffW + 1 + HistW;   // coeff times history
  localparam int unsigned YW  = HistW + 2;            // exact filter output
  localparam int unsigned P2W = SampleW + GainW + 1;  // saturated y times gain
  localparam int unsigned RemW = RampW + 1;

  // Configuration and architectural state.
  logic [CoeffW-1:0]               coeff_q;
  logic [GainW-1:0]                target_q;
  logic [RampW-1:0]                ramp_q;
  logic signed [SampleW-1:0]       xprev_q [2];
  logic signed [HistW-1:0]         yprev_q [2];
  logic [GainW-1:0]                gain_q;
  logic signed [StepW-1:0]         step_q;
  logic                            out_valid_q;

  // Per-transaction working registers.
  logic signed [SampleW-1:0]       x_q;
  logic                            ch_q;
  logic [BlenW-1:0]                blen_q;
  logic signed [P1W-1:0]           p1_q;
  logic signed [YW-1:0]            y_q;
  logic signed [P2W-1:0]           p2_q;
  logic [GainW-1:0]                num_q;
  logic [RemW-1:0]                 rem_q;
  logic [RampW-1:0]                den_q;
  logic                            neg_q;
  dcb_out_t                        out_q;

  logic signed [GainW+1:0]         diff;
  logic [GainW-1:0]                diff_mag;
  logic [BlenW-1:0]                blen_eff;
  logic [RampW-1:0]                ramp_eff;
  logic [RampW-1:0]                den_d;
  logic [RemW-1:0]                 trial;
  logic                            trial_ge;
  logic signed [StepW-1:0]         quot_s;
  logic signed [P1W-1:0]           p1_d;
  logic signed [YW-1:0]            y_d;
  logic signed [SampleW-1:0]       y_sat;
  logic signed [P2W-1:0]           p2_d;
  logic signed [StepW:0]           gain_sum;
  logic signed [StepW:0]           target_ext;
  logic [GainW-1:0]                gain_d;
  logic                            step_pos;
  logic                            step_neg;

  // Gain step division: |target - gain| / min(buffer_len, ramp_len).
  always_comb begin
    diff     = $signed({2'b00, target_q}) - $signed({2'b00, gain_q});
    diff_mag = diff[GainW+1] ? GainW'(-diff) : diff[GainW-1:0];
    blen_eff = (blen_q == '0) ? BlenW'(1) : blen_q;
    ramp_eff = (ramp_q == '0) ? RampW'(1) : ramp_q;
    den_d    = (blen_eff > BlenW'(ramp_eff)) ? ramp_eff : blen_eff[RampW-1:0];
    trial    = {rem_q[RemW-2:0], num_q[GainW-1]};
    trial_ge = (trial >= {1'b0, den_q});
    quot_s   = $signed({{(StepW-GainW){1'b0}}, num_q});
  end

  // High-pass and gain arithmetic.
  always_comb begin
    p1_d  = $signed({1'b0, coeff_q}) * $signed(P1W'(yprev_q[ch_q]));
    y_d   = YW'(x_q) - YW'(xprev_q[ch_q]) + YW'(p1_q >>> QShift);
    if (y_q > YW'(32767)) begin
      y_sat = SampleW'(32767);
    end else if (y_q < -YW'(32768)) begin
      y_sat = -SampleW'(32768);
    end else begin
      y_sat = y_q[SampleW-1:0];
    end
    p2_d  = P2W'(y_sat) * $signed({1'b0, gain_q});
  end

  // Gain ramp: one step toward the target, clamped there.
  always_comb begin
    gain_sum   = $signed({{(StepW+1-GainW){1'b0}}, gain_q}) + (StepW+1)'(step_q);
    target_ext = $signed({{(StepW+1-GainW){1'b0}}, target_q});
    step_pos   = (step_q > 0);
    step_neg   = (step_q < 0);
    gain_d     = gain_q;
    if ((step_q != '0) && (gain_q != target_q)) begin
      if ((step_pos && gain_sum >= target_ext) || (step_neg && gain_sum <= target_ext)) begin
        gain_d = target_q;
      end else begin
        gain_d = gain_sum[GainW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q     <= CoeffReset;
      target_q    <= TargetReset;
      ramp_q      <= RampReset;
      xprev_q[0]  <= '0;
      xprev_q[1]  <= '0;
      yprev_q[0]  <= '0;
      yprev_q[1]  <= '0;
      gain_q      <= TargetReset;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HPF_COEFF:   coeff_q  <= cfg_data_i[CoeffW-1:0];
          CFG_TARGET_GAIN: target_q <= cfg_data_i[GainW-1:0];
          CFG_RAMP_LEN:    ramp_q   <= cfg_data_i[RampW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load && in_data_i.clear_history) begin
        xprev_q[0] <= '0;
        xprev_q[1] <= '0;
        yprev_q[0] <= '0;
        yprev_q[1] <= '0;
      end
      if (cmd_i.add_hpf) begin
        xprev_q[ch_q] <= x_q;
        yprev_q[ch_q] <= y_d[HistW-1:0];
      end
      if (cmd_i.step_zero) begin
        step_q <= '0;
      end else if (cmd_i.div_end) begin
        if (num_q == '0) begin
          step_q <= neg_q ? -StepW'(1) : StepW'(1);
        end else begin
          step_q <= neg_q ? -quot_s : quot_s;
        end
      end
      if (cmd_i.write) begin
        gain_q      <= gain_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= in_data_i.sample_in;
      ch_q   <= in_data_i.channel;
      blen_q <= in_data_i.buffer_len;
    end
    if (cmd_i.div_init) begin
      num_q <= diff_mag;
      rem_q <= '0;
      den_q <= den_d;
      neg_q <= diff[GainW+1];
    end else if (cmd_i.div_iter) begin
      num_q <= {num_q[GainW-2:0], trial_ge};
      rem_q <= trial_ge ? (trial - {1'b0, den_q}) : trial;
    end
    if (cmd_i.mul_hpf) begin
      p1_q <= p1_d;
    end
    if (cmd_i.add_hpf) begin
      y_q <= y_d;
    end
    if (cmd_i.mul_gain) begin
      p2_q <= p2_d;
    end
    if (cmd_i.write) begin
      out_q.sample_out <= p2_q[QShift+SampleW-1:QShift];
      out_q.gain_now   <= gain_d;
    end
  end

  assign sts_o.gains_equal = (gain_q == target_q);
  assign sts_o.out_full    = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// ===== hw/rtl/dc_block_highpass_gain_ramp.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake     Payload
// in_i      sink       valid/ready   sample_in, channel, buffer_first, buffer_len,
//                                    clear_history
// out_o     source     valid/ready   sample_out, gain_now
// cfg       write      cfg_we_i      cfg_idx_i selects the register, cfg_data_i
//
// Without buffer_first a transaction goes from acceptance to the next acceptance via
// the accept step, two multiplies, one add and the output write. With buffer_first,
// one extra state clears the step when the gain is on its target; otherwise the
// divider runs first (setup, 15-bit quotient, sign fix). Reset is asynchronous and
// active low; it restores the register defaults, clears the history and the step,
// and loads the reset gain. A stalled output holds the block only in the write state.

module dc_block_highpass_gain_ramp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dcb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dcb_pkg::CfgW-1:0]    cfg_data_i,
  dcb_stream_if.sink                  in_i,
  dcb_stream_if.source                out_o
);
  import dcb_pkg::*;

  dcb_cmd_t cmd;
  dcb_sts_t sts;
  dcb_in_t  in_data;
  dcb_out_t out_data;
  logic     in_ready;
  logic     out_valid;

  assign in_data = in_i.payload;

  // The sequencer walks each transaction through the datapath; it sees the input
  // handshake, the datapath status and buffer_first so it can branch into the divider.
  dcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_first_i (in_data.buffer_first),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the registers, the filter history, the gain ramp,
  // the step divider and the output register.
  dcb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_data;

endmodule

// ===== hw/rtl/dcb_checker.sv =====
`timescale 1ns / 1ps

module dcb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input dcb_pkg::dcb_out_t out_data_i
);
  import dcb_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output transaction changed while stalled");

  // An accepted transaction keeps the input closed for the whole filter pass.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)
    else $error("input reopened before the filter pass finished");

  // A new result appears only at the end of a transaction's work.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while the block was idle");

endmodule

bind dc_block_highpass_gain_ramp dcb_checker u_dcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);
